// ----- src/assert_macros.svh -----
// Assertion macros shared by the scheduler modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The expression must hold in every cycle.
`define SDS_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");

`endif

// ----- src/sds_pkg.sv -----
package sds_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int TRACK_BITS  = 16;

	localparam int FIELD_W = 16;
	localparam int SEEK_W  = 17;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ITER_W  = $clog2(SEEK_W);

	localparam logic [FIELD_W-1:0] DISK_SIZE_RESET = 16'd200;

	localparam logic OPC_LOAD = 1'b0;
	localparam logic OPC_RUN  = 1'b1;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_PUSH,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [TRACK_BITS-1:0] x;
	} cell_cmd_t;

	typedef struct packed {
		logic                  valid;
		logic [TRACK_BITS-1:0] value;
		logic                  gt;
	} cell_link_t;

endpackage

// ----- src/scan_disk_scheduler_core.sv -----
// SCAN disk scheduler. A load transaction (opcode 0) queues one request track in a sorted
// chain of cells; loads beyond the queue depth are dropped. A run transaction (opcode 1)
// carries the head position and makes busy rise. The block first walks the sorted chain
// from the low end, one cell per cycle, moving requests below the head onto a stack chain
// and emitting requests equal to the head at once, and then finds the end of that walk.
// In ST_SEEK it picks the direction and total seek, in ST_DIV a bit-serial divider forms
// the average, and in ST_EMIT it emits the remaining requests one per cycle. A run in
// which every request equals the head, or whose queue is empty, returns to idle after
// the walk. Each result is shown for one cycle under strobe and the receiver cannot
// stall it; is_last marks the final result, which carries total_seek and average_seek.
// Write disk_size only while busy is low.
`include "assert_macros.svh"

module scan_disk_scheduler_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [sds_pkg::FIELD_W-1:0] value,
	input  logic                        disk_size_we,
	input  logic [sds_pkg::FIELD_W-1:0] disk_size,
	output logic                        strobe,
	output logic [sds_pkg::FIELD_W-1:0] track,
	output logic [sds_pkg::SEEK_W-1:0]  total_seek,
	output logic [sds_pkg::SEEK_W-1:0]  average_seek,
	output logic                        is_last
);

	localparam int D  = sds_pkg::QUEUE_DEPTH;
	localparam int TW = sds_pkg::TRACK_BITS;
	localparam int SW = sds_pkg::SEEK_W;
	localparam int CW = sds_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEEK,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                cnt_q;
	logic [sds_pkg::FIELD_W-1:0]  disk_size_q;
	logic                         strobe_q;
	logic                         last_q;
	logic [sds_pkg::FIELD_W-1:0]  track_q;
	logic [SW-1:0]                total_q;
	logic [SW-1:0]                avg_q;

	logic [TW-1:0]                head_q;
	logic [TW-1:0]                max_q;
	logic [TW-1:0]                low_min_q;
	logic [SW-1:0]                seek_q;
	logic                         dir_down_q;

	sds_pkg::cell_link_t          main_link [D];
	sds_pkg::cell_link_t          stk_link [D];
	sds_pkg::cell_cmd_t           main_cmd;
	sds_pkg::cell_cmd_t           stk_cmd;
	sds_pkg::cell_link_t          main_head;
	sds_pkg::cell_link_t          stk_head;

	logic [TW-1:0]                in_trk;
	logic                         accept;
	logic                         load_ok;
	logic                         run_go;
	logic                         scan_pop;
	logic                         scan_low;
	logic                         emit_stk;
	logic                         emit_last;
	logic [TW-1:0]                lo_gap;
	logic [TW-1:0]                hi_gap;
	logic                         go_down;
	logic [SW-1:0]                end_pt;
	logic [SW-1:0]                seek_down;
	logic [SW-1:0]                seek_up;
	logic [SW-1:0]                seek_nxt;
	logic                         div_done;
	logic [SW-1:0]                div_quot;

	assign busy    = (state_q != ST_IDLE);
	assign in_trk  = TW'(value);
	assign accept  = start && !busy;
	assign load_ok = accept && (opcode == sds_pkg::OPC_LOAD) && (cnt_q < CW'(D));
	assign run_go  = accept && (opcode == sds_pkg::OPC_RUN);

	assign scan_pop = (state_q == ST_SCAN) && main_link[0].valid
		&& (main_link[0].value <= head_q);
	assign scan_low = scan_pop && (main_link[0].value < head_q);

	assign emit_stk  = dir_down_q ? stk_link[0].valid : !main_link[0].valid;
	assign emit_last = (stk_link[0].valid && !stk_link[1].valid && !main_link[0].valid)
		|| (main_link[0].valid && !main_link[1].valid && !stk_link[0].valid);

	always_comb begin
		main_cmd.x = in_trk;
		if (load_ok) begin
			main_cmd.op = sds_pkg::OP_INSERT;
		end else if (scan_pop || ((state_q == ST_EMIT) && !emit_stk)) begin
			main_cmd.op = sds_pkg::OP_POP;
		end else begin
			main_cmd.op = sds_pkg::OP_HOLD;
		end
	end

	always_comb begin
		stk_cmd.x = main_link[0].value;
		if (scan_low) begin
			stk_cmd.op = sds_pkg::OP_PUSH;
		end else if ((state_q == ST_EMIT) && emit_stk) begin
			stk_cmd.op = sds_pkg::OP_POP;
		end else begin
			stk_cmd.op = sds_pkg::OP_HOLD;
		end
	end

	assign main_head.valid = 1'b1;
	assign main_head.value = main_cmd.x;
	assign main_head.gt    = 1'b0;
	assign stk_head.valid  = 1'b1;
	assign stk_head.value  = stk_cmd.x;
	assign stk_head.gt     = 1'b0;

	for (genvar i = 0; i < D; i++) begin : g_cells
		sds_pkg::cell_link_t main_left;
		sds_pkg::cell_link_t main_right;
		sds_pkg::cell_link_t stk_left;
		sds_pkg::cell_link_t stk_right;

		if (i == 0) begin : g_first
			assign main_left = main_head;
			assign stk_left  = stk_head;
		end else begin : g_inner
			assign main_left = main_link[i-1];
			assign stk_left  = stk_link[i-1];
		end

		if (i == D - 1) begin : g_last
			assign main_right = '0;
			assign stk_right  = '0;
		end else begin : g_body
			assign main_right = main_link[i+1];
			assign stk_right  = stk_link[i+1];
		end

		sds_cell u_main_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (main_cmd),
			.left   (main_left),
			.right  (main_right),
			.link   (main_link[i])
		);

		sds_cell u_stk_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (stk_cmd),
			.left   (stk_left),
			.right  (stk_right),
			.link   (stk_link[i])
		);
	end

	assign lo_gap  = head_q - stk_link[0].value;
	assign hi_gap  = main_link[0].value - head_q;
	assign go_down = !main_link[0].valid || (stk_link[0].valid && (lo_gap < hi_gap));

	always_comb begin
		end_pt = SW'(disk_size_q);
		if (SW'(head_q) > end_pt) begin
			end_pt = SW'(head_q);
		end
		if (SW'(max_q) > end_pt) begin
			end_pt = SW'(max_q);
		end
	end

	assign seek_down = SW'(head_q) + (main_link[0].valid ? SW'(max_q) : '0);
	assign seek_up   = (end_pt - SW'(head_q))
		+ (stk_link[0].valid ? (end_pt - SW'(low_min_q)) : '0);
	assign seek_nxt  = go_down ? seek_down : seek_up;

	sds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_SEEK),
		.dividend (seek_nxt),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			disk_size_q <= sds_pkg::DISK_SIZE_RESET;
			strobe_q    <= 1'b0;
			last_q      <= 1'b0;
			track_q     <= '0;
			total_q     <= '0;
			avg_q       <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			if (disk_size_we) begin
				disk_size_q <= disk_size;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_ok) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (run_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_pop) begin
						if (!scan_low) begin
							strobe_q <= 1'b1;
							track_q  <= sds_pkg::FIELD_W'(main_link[0].value);
							total_q  <= '0;
							avg_q    <= '0;
							last_q   <= !stk_link[0].valid && !main_link[1].valid;
						end
					end else if (!main_link[0].valid && !stk_link[0].valid) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						state_q <= ST_SEEK;
					end
				end
				ST_SEEK: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					last_q   <= emit_last;
					track_q  <= sds_pkg::FIELD_W'(emit_stk ? stk_link[0].value
						: main_link[0].value);
					total_q  <= emit_last ? seek_q : '0;
					avg_q    <= emit_last ? div_quot : '0;
					if (emit_last) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			max_q <= ((cnt_q == '0) || (in_trk > max_q)) ? in_trk : max_q;
		end
		if (run_go) begin
			head_q <= in_trk;
		end
		if (scan_low && !stk_link[0].valid) begin
			low_min_q <= main_link[0].value;
		end
		if (state_q == ST_SEEK) begin
			seek_q     <= seek_nxt;
			dir_down_q <= go_down;
		end
	end

	assign strobe       = strobe_q;
	assign track        = track_q;
	assign total_seek   = total_q;
	assign average_seek = avg_q;
	assign is_last      = last_q;

	for (genvar i = 1; i < D; i++) begin : g_chk
		`SDS_ASSERT_IMPL(a_chain_sorted, main_link[i].valid,
			main_link[i-1].valid && (main_link[i-1].value <= main_link[i].value))
	end

	`SDS_ASSERT_IMPL(a_last_has_strobe, is_last, strobe)
	`SDS_ASSERT_NEXT(a_run_goes_busy, start && !busy && (opcode == sds_pkg::OPC_RUN), busy)
	`SDS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(D))

endmodule

// ----- src/sds_cell.sv -----
module sds_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sds_pkg::cell_cmd_t cmd,
	input  sds_pkg::cell_link_t left,
	input  sds_pkg::cell_link_t right,
	output sds_pkg::cell_link_t link
);

	logic                           valid_q;
	logic [sds_pkg::TRACK_BITS-1:0] value_q;
	logic                           gt;
	logic                           valid_nxt;
	logic [sds_pkg::TRACK_BITS-1:0] value_nxt;

	assign gt = valid_q && (value_q > cmd.x);

	always_comb begin
		valid_nxt = valid_q;
		value_nxt = value_q;
		unique case (cmd.op)
			sds_pkg::OP_HOLD: begin
			end
			sds_pkg::OP_INSERT: begin
				if (left.gt) begin
					valid_nxt = left.valid;
					value_nxt = left.value;
				end else if (gt || (!valid_q && left.valid)) begin
					valid_nxt = 1'b1;
					value_nxt = cmd.x;
				end
			end
			sds_pkg::OP_PUSH: begin
				valid_nxt = left.valid;
				value_nxt = left.value;
			end
			sds_pkg::OP_POP: begin
				valid_nxt = right.valid;
				value_nxt = right.value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

	assign link.valid = valid_q;
	assign link.value = value_q;
	assign link.gt    = gt;

endmodule

// ----- src/sds_div.sv -----
`include "assert_macros.svh"

module sds_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sds_pkg::SEEK_W-1:0] dividend,
	input  logic [sds_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [sds_pkg::SEEK_W-1:0] quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [sds_pkg::ITER_W-1:0]  iter_q;
	logic [sds_pkg::SEEK_W-1:0]  num_q;
	logic [sds_pkg::CNT_W-1:0]   rem_q;
	logic [sds_pkg::CNT_W-1:0]   div_q;
	logic [sds_pkg::CNT_W:0]     rem_sh;
	logic                        fits;
	logic [sds_pkg::CNT_W:0]     rem_sub;

	assign rem_sh  = {rem_q, num_q[sds_pkg::SEEK_W-1]};
	assign fits    = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= sds_pkg::ITER_W'(sds_pkg::SEEK_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[sds_pkg::SEEK_W-2:0], fits};
			rem_q <= fits ? rem_sub[sds_pkg::CNT_W-1:0] : rem_sh[sds_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

	`SDS_ASSERT_NEXT(a_div_done_idle, done_q, !busy_q || start)

endmodule
